// ----- src/qfts_pkg.sv -----
package qfts_pkg;

  // Width of the stored and delivered value.
  localparam int unsigned DataWidth = 32;

  // Operation carried in the request's tuser.
  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  // Result status carried in the response's tuser.
  typedef enum logic [1:0] {
    STATUS_ENQUEUED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_DEQUEUED = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_POP
  } state_e;

endpackage

// ----- src/qfts_ram.sv -----
module qfts_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/queue_from_two_stacks_unit.sv -----
// First-in first-out queue built from two stacks of STACK_DEPTH entries, each held in a
// synchronous RAM. A request carries the operation in s_axis_tuser_i (0 enqueue, 1 dequeue)
// and the value in s_axis_tdata_i; every request gives exactly one response with the dequeued
// value in m_axis_tdata_o and the status in m_axis_tuser_o (0 enqueued, 1 dropped because the
// input stack is full, 2 dequeued, 3 queue empty). An enqueue, a full drop and an empty answer
// appear in the response register in the cycle after they are taken; a dequeue from a filled
// output stack reads the RAM when taken and registers the value in ST_POP; a dequeue that finds
// the output stack empty first moves the entries of the input stack across in ST_MOVE, one RAM
// read and write per cycle, and answers once the input stack is empty. One request is worked on
// at a time, and the next is taken as soon as the response register is free or being drained.
module queue_from_two_stacks_unit #(
  parameter int unsigned STACK_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] push_value
  input  logic        s_axis_tuser_i,  // [0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [31:0] out_value
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = qfts_pkg::DataWidth;
  localparam logic [CW-1:0] DepthC = CW'(STACK_DEPTH);

  qfts_pkg::state_e state_q, state_d;
  logic [CW-1:0]    first_count_q, first_count_d;
  logic [CW-1:0]    second_count_q, second_count_d;

  logic             out_valid_q, out_valid_d;
  logic [DW-1:0]    out_data_q, out_data_d;
  qfts_pkg::status_e out_status_q, out_status_d;

  logic             first_we, first_re, second_we, second_re;
  logic [AW-1:0]    first_waddr, first_raddr, second_waddr, second_raddr;
  logic [DW-1:0]    first_rdata, second_rdata;
  logic [CW-1:0]    first_top, second_top;
  logic             accept;

  assign first_top  = first_count_q - 1'b1;
  assign second_top = second_count_q - 1'b1;

  // A request is taken only while idle and with room in the response register.
  assign s_axis_tready_o = (state_q == qfts_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Input stack: pushed by enqueues, popped during a transfer.
  qfts_ram #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(DW)
  ) u_first_ram (
    .clk_i  (clk_i),
    .we_i   (first_we),
    .waddr_i(first_waddr),
    .wdata_i(s_axis_tdata_i),
    .re_i   (first_re),
    .raddr_i(first_raddr),
    .rdata_o(first_rdata)
  );

  // Output stack: filled during a transfer, popped by dequeues.
  qfts_ram #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(DW)
  ) u_second_ram (
    .clk_i  (clk_i),
    .we_i   (second_we),
    .waddr_i(second_waddr),
    .wdata_i(first_rdata),
    .re_i   (second_re),
    .raddr_i(second_raddr),
    .rdata_o(second_rdata)
  );

  assign first_waddr  = first_count_q[AW-1:0];
  assign first_raddr  = first_top[AW-1:0];
  assign second_waddr = second_count_q[AW-1:0];
  assign second_raddr = second_top[AW-1:0];

  // Sequencer: next state, counts, RAM strobes and the response register.
  always_comb begin
    state_d        = state_q;
    first_count_d  = first_count_q;
    second_count_d = second_count_q;
    out_valid_d    = out_valid_q && !m_axis_tready_i;
    out_data_d     = out_data_q;
    out_status_d   = out_status_q;
    first_we       = 1'b0;
    first_re       = 1'b0;
    second_we      = 1'b0;
    second_re      = 1'b0;

    unique case (state_q)
      qfts_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i == qfts_pkg::OP_ENQUEUE) begin
            out_valid_d = 1'b1;
            out_data_d  = '0;
            if (first_count_q < DepthC) begin
              first_we      = 1'b1;
              first_count_d = first_count_q + 1'b1;
              out_status_d  = qfts_pkg::STATUS_ENQUEUED;
            end else begin
              out_status_d = qfts_pkg::STATUS_FULL;
            end
          end else if (second_count_q != '0) begin
            second_re      = 1'b1;
            second_count_d = second_top;
            state_d        = qfts_pkg::ST_POP;
          end else if (first_count_q != '0) begin
            first_re      = 1'b1;
            first_count_d = first_top;
            state_d       = qfts_pkg::ST_MOVE;
          end else begin
            out_valid_d  = 1'b1;
            out_data_d   = '0;
            out_status_d = qfts_pkg::STATUS_EMPTY;
          end
        end
      end

      qfts_pkg::ST_MOVE: begin
        if (first_count_q != '0) begin
          // Move the entry just read and fetch the next one down.
          second_we      = 1'b1;
          second_count_d = second_count_q + 1'b1;
          first_re       = 1'b1;
          first_count_d  = first_top;
        end else begin
          // The oldest entry comes out last: deliver it without storing it.
          out_valid_d  = 1'b1;
          out_data_d   = first_rdata;
          out_status_d = qfts_pkg::STATUS_DEQUEUED;
          state_d      = qfts_pkg::ST_IDLE;
        end
      end

      qfts_pkg::ST_POP: begin
        out_valid_d  = 1'b1;
        out_data_d   = second_rdata;
        out_status_d = qfts_pkg::STATUS_DEQUEUED;
        state_d      = qfts_pkg::ST_IDLE;
      end

      default: begin
        state_d = qfts_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= qfts_pkg::ST_IDLE;
      first_count_q  <= '0;
      second_count_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      first_count_q  <= first_count_d;
      second_count_q <= second_count_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Response payload.
  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

  // Counts never pass the stack depth.
  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_count_q <= DepthC) && (second_count_q <= DepthC))
    else $error("stack count exceeds depth");

  // A transfer only runs while the output stack started empty, so it never overflows.
  a_move_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qfts_pkg::ST_MOVE) |-> (second_count_q < DepthC))
    else $error("transfer overflows output stack");

  // While a dequeue is in flight the response register is free.
  a_busy_no_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != qfts_pkg::ST_IDLE) |-> (!out_valid_q && !s_axis_tready_o))
    else $error("response pending while dequeue in progress");

  // A dequeue on an empty queue answers empty in the next cycle.
  a_empty_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_axis_tuser_i == qfts_pkg::OP_DEQUEUE) && (first_count_q == '0) &&
     (second_count_q == '0)) |=> (out_valid_q && (out_status_q == qfts_pkg::STATUS_EMPTY)))
    else $error("empty dequeue not answered");

endmodule

// ----- tb/sv/tb_queue_from_two_stacks_unit.sv -----
module tb_queue_from_two_stacks_unit;

  localparam int unsigned StackDepth = 8;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 24;

  // One expected response: the dequeued value and its status.
  typedef struct packed {
    logic [31:0]       value;
    qfts_pkg::status_e status;
  } queue_response_t;

  // Behavioural copy of the two-stack queue with its list of outstanding responses.
  class queue_scoreboard;
    logic [31:0]     in_stack[StackDepth];
    int unsigned     in_count;
    logic [31:0]     out_stack[StackDepth];
    int unsigned     out_count;
    queue_response_t pending_responses[$];
    int unsigned     error_count;

    function new();
      in_count    = 0;
      out_count   = 0;
      error_count = 0;
    endfunction

    // Works out the response to an accepted request and records it.
    function void note_request(qfts_pkg::op_e op, logic [31:0] value);
      queue_response_t rsp;
      rsp.value = '0;
      if (op == qfts_pkg::OP_ENQUEUE) begin
        if (in_count < StackDepth) begin
          in_stack[in_count] = value;
          in_count++;
          rsp.status = qfts_pkg::STATUS_ENQUEUED;
        end else begin
          rsp.status = qfts_pkg::STATUS_FULL;
        end
      end else begin
        // An empty output stack is refilled from the input stack, top first.
        if (out_count == 0) begin
          while (in_count > 0 && out_count < StackDepth) begin
            in_count--;
            out_stack[out_count] = in_stack[in_count];
            out_count++;
          end
        end
        if (out_count > 0) begin
          out_count--;
          rsp.value  = out_stack[out_count];
          rsp.status = qfts_pkg::STATUS_DEQUEUED;
        end else begin
          rsp.status = qfts_pkg::STATUS_EMPTY;
        end
      end
      pending_responses.push_back(rsp);
    endfunction

    // Compares an accepted response with the oldest expectation.
    function void check_response(logic [31:0] value, logic [1:0] status);
      queue_response_t exp_rsp;
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected response value %h status %0d", $time, value, status);
        error_count++;
        return;
      end
      exp_rsp = pending_responses.pop_front();
      if (value !== exp_rsp.value) begin
        $display("%0t: value mismatch, expected %h, actual %h", $time, exp_rsp.value, value);
        error_count++;
      end
      if (status !== exp_rsp.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, exp_rsp.status,
                 status);
        error_count++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;  // [31:0] push_value
  logic        s_axis_tuser_i = 1'b0;  // [0] op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;  // [31:0] out_value
  logic [1:0]  m_axis_tuser_o;  // [1:0] status

  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     cycle_count = 0;
  queue_scoreboard queue_model = new();

  queue_from_two_stacks_unit #(
    .STACK_DEPTH(StackDepth)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Free-running clock.
  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Response side stalls at random.
  always @(negedge clk_i) begin
    m_axis_tready_i = ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted response is checked against the queue model.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      queue_model.check_response(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // Offers one request, idling first at random, and notes it once it is taken.
  task automatic drive_request(input qfts_pkg::op_e op, input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = value;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    queue_model.note_request(op, value);
    @(negedge clk_i);
  endtask

  // Holds requests back until every outstanding response has come.
  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (queue_model.pending_responses.size() != 0) @(negedge clk_i);
  endtask

  // Values lean towards the extremes now and then, otherwise fully random.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Bursts of one operation, so that the stacks swing between full and empty.
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned   sent;
    int unsigned   burst_len;
    qfts_pkg::op_e op;
    sent = 0;
    while (sent < n_items) begin
      op        = $urandom_range(1) ? qfts_pkg::OP_DEQUEUE : qfts_pkg::OP_ENQUEUE;
      burst_len = $urandom_range(1) ? 1 : $urandom_range(2, 10);
      for (int unsigned k = 0; k < burst_len && sent < n_items; k++) begin
        drive_request(op, pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty queue, extreme values, transfer, full input stack.
    drive_request(qfts_pkg::OP_DEQUEUE, 32'h1234_5678);
    drive_request(qfts_pkg::OP_ENQUEUE, 32'h8000_0000);
    drive_request(qfts_pkg::OP_ENQUEUE, 32'h7fff_ffff);
    drive_request(qfts_pkg::OP_ENQUEUE, 32'hffff_ffff);
    drive_request(qfts_pkg::OP_ENQUEUE, 32'h0000_0000);
    drive_request(qfts_pkg::OP_DEQUEUE, 32'hffff_ffff);
    drive_request(qfts_pkg::OP_ENQUEUE, 32'haaaa_aaaa);
    drive_request(qfts_pkg::OP_ENQUEUE, 32'h5555_5555);
    repeat (StackDepth - 2) drive_request(qfts_pkg::OP_ENQUEUE, $urandom);
    drive_request(qfts_pkg::OP_ENQUEUE, 32'hdead_beef);
    repeat (3) drive_request(qfts_pkg::OP_DEQUEUE, 32'h0);
    // The output stack is now empty, so this moves a full input stack across.
    drive_request(qfts_pkg::OP_DEQUEUE, 32'h0);
    drive_request(qfts_pkg::OP_ENQUEUE, 32'hffff_ffff);
    drive_request(qfts_pkg::OP_DEQUEUE, 32'h0);

    // Random phases with different idling on each side.
    send_idle_pct  = 32;
    recv_stall_pct = 73;
    run_random_phase(360);
    wait_drained();
    send_idle_pct  = 73;
    recv_stall_pct = 32;
    run_random_phase(360);
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_phase(360);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (queue_model.error_count == 0 && queue_model.pending_responses.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
